/* rtl/core/tccw_pkg.sv */
package tccw_pkg;

   // Field widths of the channels
   localparam int OP_W   = 2;
   localparam int CHAR_W = 8;
   localparam int ADDR_W = 11;
   localparam int CELL_W = 16;
   localparam int ATTR_W = 8;

   // Character codes with a meaning of their own
   localparam logic [CHAR_W-1:0] CHAR_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CHAR_BACKSPACE = 8'h08;

   // Blank cell: grey on black, space
   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

   typedef enum logic [OP_W-1:0] {
      OP_PUT   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_EXEC,
      ST_COPY_RD,
      ST_COPY_WR,
      ST_BLANK,
      ST_READ_WAIT,
      ST_FINISH
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic execute;
      logic copy_rd;
      logic copy_wr;
      logic blank_wr;
      logic read_load;
      logic rsp_load;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      op_type op;
      logic   wrap;
      logic   read_hit;
      logic   copy_last;
      logic   blank_last;
      logic   rsp_free;
   } status_type;

endpackage

/* rtl/core/tccw_req_if.sv */
interface tccw_req_if;
   import tccw_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   operation;
   logic [CHAR_W-1:0] char_code;
   logic [ADDR_W-1:0] read_address;

   modport source (output valid, output operation, output char_code, output read_address,
                   input ready);
   modport sink (input valid, input operation, input char_code, input read_address,
                 output ready);
endinterface

/* rtl/core/tccw_rsp_if.sv */
interface tccw_rsp_if;
   import tccw_pkg::*;

   logic              valid;
   logic              ready;
   logic [ADDR_W-1:0] cursor_position;
   logic [CELL_W-1:0] cell_value;

   modport source (output valid, output cursor_position, output cell_value, input ready);
   modport sink (input valid, input cursor_position, input cell_value, output ready);
endinterface

/* rtl/core/tccw_csr_if.sv */
interface tccw_csr_if;
   import tccw_pkg::*;

   logic              valid;
   logic              ready;
   logic [ATTR_W-1:0] text_attribute;

   modport source (output valid, output text_attribute, input ready);
   modport sink (input valid, input text_attribute, output ready);
endinterface

/* rtl/core/tccw_ram.sv */
module tccw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/core/tccw_ctrl.sv */
module tccw_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tccw_pkg::status_type   status,
   output tccw_pkg::cmd_type      cmd
);
   import tccw_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register; reset starts the clearing sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT: begin
            if (status.blank_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            unique case (status.op)
               OP_PUT:   state_in = status.wrap ? ST_COPY_RD : ST_FINISH;
               OP_CLEAR: state_in = ST_BLANK;
               OP_READ:  state_in = status.read_hit ? ST_READ_WAIT : ST_FINISH;
               default:  state_in = ST_FINISH;
            endcase
         end
         ST_COPY_RD: begin
            state_in = ST_COPY_WR;
         end
         ST_COPY_WR: begin
            state_in = status.copy_last ? ST_BLANK : ST_COPY_RD;
         end
         ST_BLANK: begin
            if (status.blank_last) state_in = ST_FINISH;
         end
         ST_READ_WAIT: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   // Outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            cmd.blank_wr = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_COPY_RD: begin
            cmd.copy_rd = 1'b1;
         end
         ST_COPY_WR: begin
            cmd.copy_wr = 1'b1;
         end
         ST_BLANK: begin
            cmd.blank_wr = 1'b1;
         end
         ST_READ_WAIT: begin
            cmd.read_load = 1'b1;
         end
         ST_FINISH: begin
            cmd.rsp_load = status.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end
endmodule

/* rtl/core/tccw_dpath.sv */
module tccw_dpath #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tccw_pkg::cmd_type             cmd,
   output tccw_pkg::status_type          status,
   input  logic [tccw_pkg::OP_W-1:0]     req_operation,
   input  logic [tccw_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [tccw_pkg::ADDR_W-1:0]   req_read_address,
   input  logic                          csr_valid,
   input  logic [tccw_pkg::ATTR_W-1:0]   csr_text_attribute,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [tccw_pkg::ADDR_W-1:0]   rsp_cursor_position,
   output logic [tccw_pkg::CELL_W-1:0]   rsp_cell_value
);
   import tccw_pkg::*;

   localparam int CELL_COUNT = COLUMNS * ROWS;
   localparam int CW         = $clog2(CELL_COUNT);
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int XW         = (CW > ADDR_W) ? CW : ADDR_W;

   localparam logic [CW:0]      CELLS_N   = (CW+1)'(CELL_COUNT);
   localparam logic [CW:0]      ROW_N     = (CW+1)'(COLUMNS);
   localparam logic [CW-1:0]    ROW_STEP  = CW'(COLUMNS);
   localparam logic [CW-1:0]    LAST_ROW  = CW'(CELL_COUNT - COLUMNS);
   localparam logic [CW-1:0]    LAST_COPY = CW'(CELL_COUNT - COLUMNS - 1);
   localparam logic [CW-1:0]    LAST_CELL = CW'(CELL_COUNT - 1);
   localparam logic [COL_W-1:0] COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [XW-1:0]    CELLS_X   = XW'(CELL_COUNT);

   // Latched transaction
   op_type            op_ff;
   logic [CHAR_W-1:0] char_ff;
   logic [ADDR_W-1:0] addr_ff;

   // Control state
   logic [ATTR_W-1:0] attr_ff,   attr_in;
   logic [CW-1:0]     cursor_ff, cursor_in;
   logic [COL_W-1:0]  col_ff,    col_in;
   logic [CW-1:0]     ptr_ff,    ptr_in;
   logic              rsp_valid_ff, rsp_valid_in;

   // Result payload
   logic [CELL_W-1:0] cell_ff;
   logic [ADDR_W-1:0] rsp_cursor_ff;
   logic [CELL_W-1:0] rsp_cell_ff;

   // Put-character evaluation
   logic              put_wr;
   logic [CW-1:0]     put_addr;
   logic [CELL_W-1:0] put_data;
   logic [CW:0]       cur_sum;
   logic [COL_W-1:0]  col_next;
   logic              wrap;
   logic [CW-1:0]     cursor_next;
   logic              read_hit;
   logic [XW-1:0]     cursor_wide;

   // Memory port
   logic              ram_wr_en;
   logic [CW-1:0]     ram_wr_addr;
   logic [CELL_W-1:0] ram_wr_data;
   logic              ram_rd_en;
   logic [CW-1:0]     ram_rd_addr;
   logic [CELL_W-1:0] ram_rd_data;

   // Work out the effect of one character on cursor and screen
   always_comb begin
      put_wr   = 1'b0;
      put_addr = cursor_ff;
      put_data = {attr_ff, char_ff};
      cur_sum  = {1'b0, cursor_ff};
      col_next = col_ff;
      if (char_ff == CHAR_NEWLINE) begin
         cur_sum  = {1'b0, cursor_ff} + (ROW_N - (CW+1)'(col_ff));
         col_next = '0;
      end else if (char_ff == CHAR_BACKSPACE) begin
         if (cursor_ff != '0) begin
            cur_sum  = {1'b0, cursor_ff} - (CW+1)'(1);
            put_wr   = 1'b1;
            put_addr = cursor_ff - CW'(1);
            put_data = BLANK_CELL;
            col_next = (col_ff == '0) ? COL_LAST : col_ff - COL_W'(1);
         end
      end else begin
         put_wr   = 1'b1;
         cur_sum  = {1'b0, cursor_ff} + (CW+1)'(1);
         col_next = (col_ff == COL_LAST) ? '0 : col_ff + COL_W'(1);
      end
      wrap        = (cur_sum == CELLS_N);
      cursor_next = wrap ? LAST_ROW : cur_sum[CW-1:0];
   end

   assign read_hit = (XW'(addr_ff) < CELLS_X);

   // Memory write and read selection
   always_comb begin
      ram_wr_en   = (cmd.execute && (op_ff == OP_PUT) && put_wr) || cmd.copy_wr || cmd.blank_wr;
      ram_wr_addr = cmd.execute ? put_addr : ptr_ff;
      if (cmd.copy_wr) begin
         ram_wr_data = ram_rd_data;
      end else if (cmd.blank_wr) begin
         ram_wr_data = BLANK_CELL;
      end else begin
         ram_wr_data = put_data;
      end
      ram_rd_en   = (cmd.execute && (op_ff == OP_READ) && read_hit) || cmd.copy_rd;
      ram_rd_addr = cmd.copy_rd ? ptr_ff + ROW_STEP : CW'(addr_ff);
   end

   tccw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Next values of the control registers
   always_comb begin
      attr_in   = csr_valid ? csr_text_attribute : attr_ff;
      cursor_in = cursor_ff;
      col_in    = col_ff;
      ptr_in    = ptr_ff;
      if (cmd.execute) begin
         ptr_in = '0;
         if (op_ff == OP_PUT) begin
            cursor_in = cursor_next;
            col_in    = col_next;
         end else if (op_ff == OP_CLEAR) begin
            cursor_in = '0;
            col_in    = '0;
         end
      end else if (cmd.copy_wr || cmd.blank_wr) begin
         ptr_in = ptr_ff + CW'(1);
      end
      rsp_valid_in = cmd.rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         cursor_ff    <= '0;
         col_ff       <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         cursor_ff    <= cursor_in;
         col_ff       <= col_in;
         ptr_ff       <= ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign cursor_wide = XW'(cursor_ff);

   // Capture the transaction, the cell read and the result
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= op_type'(req_operation);
         char_ff <= req_char_code;
         addr_ff <= req_read_address;
      end
      if (cmd.execute) begin
         cell_ff <= '0;
      end else if (cmd.read_load) begin
         cell_ff <= ram_rd_data;
      end
      if (cmd.rsp_load) begin
         rsp_cursor_ff <= cursor_wide[ADDR_W-1:0];
         rsp_cell_ff   <= cell_ff;
      end
   end

   // Status to the controller
   always_comb begin
      status.op         = op_ff;
      status.wrap       = wrap;
      status.read_hit   = read_hit;
      status.copy_last  = (ptr_ff == LAST_COPY);
      status.blank_last = (ptr_ff == LAST_CELL);
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_cursor_ff;
   assign rsp_cell_value      = rsp_cell_ff;
endmodule

/* rtl/core/text_console_char_writer_unit.sv */
// Text console character writer: a COLUMNS x ROWS grid of 16-bit cells held in one
// single-port-write, registered-read RAM, with a linear cursor.
// req_port carries one transaction: put character, clear screen, read one cell or no-op.
// rsp_port returns one result per transaction: the cursor after it and, for a
// read, the cell (attribute high byte, character low byte), else zero.
// csr_port writes the attribute byte used for characters other than newline and
// backspace; it is always ready. The user must see that it is written only while
// the unit is idle; the unit itself does not enforce this. A request is captured
// in IDLE, executed in EXEC, passes READ_WAIT for an in-range read, has its result
// loaded into the output register in FINISH, and only then is a new one taken.
// A character that runs past the last cell scrolls: each cell is copied up one
// row through the one RAM port pair, read in COPY_RD and written in COPY_WR,
// then the bottom row is blanked at one cell per cycle.
// Clear screen blanks all COLUMNS*ROWS cells at one cell per cycle.
// After reset the unit sweeps blanks through all COLUMNS*ROWS cells before it
// accepts a request; attribute resets to 0x07, cursor to 0.
// A stalled result is held in the output register; the next request is still
// accepted and processed, and its result waits until the output register frees.
module text_console_char_writer_unit #(
   parameter int COLUMNS = 80,
   parameter int ROWS    = 25
) (
   input  logic              clock,
   input  logic              reset,
   tccw_req_if.sink          req_port,
   tccw_rsp_if.source        rsp_port,
   tccw_csr_if.sink          csr_port
);
   import tccw_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Register writes are always taken
   assign csr_port.ready = 1'b1;

   tccw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tccw_dpath #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_dpath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_operation       (req_port.operation),
      .req_char_code       (req_port.char_code),
      .req_read_address    (req_port.read_address),
      .csr_valid           (csr_port.valid),
      .csr_text_attribute  (csr_port.text_attribute),
      .rsp_ready           (rsp_port.ready),
      .rsp_valid           (rsp_port.valid),
      .rsp_cursor_position (rsp_port.cursor_position),
      .rsp_cell_value      (rsp_port.cell_value)
   );
endmodule

/* tb/sv/tccw_tb_pkg.sv */
`timescale 1ns / 1ps

package tccw_tb_pkg;
   import tccw_pkg::*;

   // Screen geometry used for the instance under test
   localparam int SCREEN_COLUMNS = 80;
   localparam int SCREEN_ROWS    = 25;
   localparam int SCREEN_CELLS   = SCREEN_COLUMNS * SCREEN_ROWS;

   typedef struct packed {
      logic [ADDR_W-1:0] cursor_position;
      logic [CELL_W-1:0] cell_value;
   } console_result_type;

   // Console screen predictor with a queue of results still to arrive
   class console_scoreboard;
      logic [CELL_W-1:0]  screen [SCREEN_CELLS];
      int unsigned        cursor_index;
      logic [ATTR_W-1:0]  attribute;
      console_result_type result_q[$];
      int unsigned        mismatches;

      function new();
         blank_screen();
         cursor_index = 0;
         attribute    = ATTR_RESET;
         mismatches   = 0;
      endfunction

      function void blank_screen();
         foreach (screen[i]) screen[i] = BLANK_CELL;
      endfunction

      function int unsigned pending();
         return result_q.size();
      endfunction

      // Apply one accepted transaction to the screen copy and queue its result
      function void note_request(op_type op, logic [CHAR_W-1:0] char_code,
                                 logic [ADDR_W-1:0] read_address);
         console_result_type want;
         want.cell_value = '0;
         case (op)
            OP_PUT: begin
               if (cursor_index >= SCREEN_CELLS) cursor_index = 0;
               if (char_code == CHAR_NEWLINE) begin
                  cursor_index += SCREEN_COLUMNS - cursor_index % SCREEN_COLUMNS;
               end else if (char_code == CHAR_BACKSPACE) begin
                  // nothing to erase at the home position
                  if (cursor_index > 0) begin
                     cursor_index--;
                     screen[cursor_index] = BLANK_CELL;
                  end
               end else begin
                  screen[cursor_index] = {attribute, char_code};
                  cursor_index++;
               end
               // run off the end: move every row up, blank the bottom one
               if (cursor_index >= SCREEN_CELLS) begin
                  for (int i = 0; i < SCREEN_CELLS - SCREEN_COLUMNS; i++)
                     screen[i] = screen[i + SCREEN_COLUMNS];
                  for (int i = SCREEN_CELLS - SCREEN_COLUMNS; i < SCREEN_CELLS; i++)
                     screen[i] = BLANK_CELL;
                  cursor_index -= SCREEN_COLUMNS;
               end
            end
            OP_CLEAR: begin
               blank_screen();
               cursor_index = 0;
            end
            OP_READ: begin
               if (read_address < SCREEN_CELLS) want.cell_value = screen[read_address];
            end
            default: ;
         endcase
         want.cursor_position = ADDR_W'(cursor_index);
         result_q.push_back(want);
      endfunction

      // Compare one accepted result with the oldest outstanding one
      function void check_response(logic [ADDR_W-1:0] cursor_position,
                                   logic [CELL_W-1:0] cell_value);
         console_result_type want;
         if (result_q.size() == 0) begin
            $error("unexpected result: cursor_position %0d, cell_value 0x%04h",
                   cursor_position, cell_value);
            mismatches++;
         end else begin
            want = result_q.pop_front();
            if (cursor_position !== want.cursor_position) begin
               $error("cursor_position: expected %0d, actual %0d",
                      want.cursor_position, cursor_position);
               mismatches++;
            end
            if (cell_value !== want.cell_value) begin
               $error("cell_value: expected 0x%04h, actual 0x%04h",
                      want.cell_value, cell_value);
               mismatches++;
            end
         end
      endfunction
   endclass

endpackage

/* tb/sv/text_console_char_writer_unit_tb.sv */
`timescale 1ns / 1ps

module text_console_char_writer_unit_tb;
   import tccw_pkg::*;
   import tccw_tb_pkg::*;

   // Longest quiet spell allowed: reset sweep, a full scroll and a stall, with margin
   localparam int QUIET_LIMIT  = 20000;
   localparam int PHASE_ITEMS  = 207;
   localparam int SETTLE_TICKS = 8;

   logic clock;
   logic reset;

   tccw_req_if req_bus ();
   tccw_rsp_if rsp_bus ();
   tccw_csr_if csr_bus ();

   console_scoreboard console_model;
   bit                req_burst;
   bit                rsp_burst;
   int unsigned       quiet_cycles;

   text_console_char_writer_unit #(
      .COLUMNS (SCREEN_COLUMNS),
      .ROWS    (SCREEN_ROWS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Present one transaction after a random gap and hold it until taken
   task automatic send_request(op_type op, logic [CHAR_W-1:0] char_code,
                               logic [ADDR_W-1:0] read_address);
      int unsigned gap;
      if ($urandom_range(0, 24) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid        <= 1'b1;
      req_bus.operation    <= op;
      req_bus.char_code    <= char_code;
      req_bus.read_address <= read_address;
      do @(posedge clock); while (!req_bus.ready);
      console_model.note_request(op, char_code, read_address);
   endtask

   // Drop the request, then wait for every outstanding result and a settling pause
   task automatic quiesce();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (console_model.pending() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_attribute(logic [ATTR_W-1:0] value);
      quiesce();
      @(negedge clock);
      csr_bus.valid          <= 1'b1;
      csr_bus.text_attribute <= value;
      do @(posedge clock); while (!csr_bus.ready);
      console_model.attribute = value;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   // Mostly text with line breaks and reads near the cursor, some noise
   task automatic run_random_phase(int unsigned items);
      int unsigned       pick;
      int unsigned       back;
      logic [CHAR_W-1:0] char_byte;
      logic [ADDR_W-1:0] addr;
      for (int unsigned n = 0; n < items; n++) begin
         pick      = $urandom_range(0, 999);
         char_byte = CHAR_W'($urandom_range(0, 255));
         addr      = ADDR_W'($urandom_range(0, (1 << ADDR_W) - 1));
         if (pick < 440 || pick >= 903) begin
            send_request(OP_PUT, char_byte, addr);
         end else if (pick < 590) begin
            send_request(OP_PUT, CHAR_NEWLINE, addr);
         end else if (pick < 660) begin
            send_request(OP_PUT, CHAR_BACKSPACE, addr);
         end else if (pick < 880) begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3: begin
                  back = $urandom_range(0, SCREEN_COLUMNS);
                  addr = (console_model.cursor_index > back) ?
                         ADDR_W'(console_model.cursor_index - back) : '0;
               end
               4, 5, 6: addr = ADDR_W'($urandom_range(0, SCREEN_CELLS - 1));
               7, 8:    addr = ADDR_W'($urandom_range(SCREEN_CELLS - 2 * SCREEN_COLUMNS,
                                                      SCREEN_CELLS - 1));
               default: addr = ADDR_W'($urandom_range(SCREEN_CELLS, (1 << ADDR_W) - 1));
            endcase
            send_request(OP_READ, char_byte, addr);
         end else if (pick < 900) begin
            send_request(OP_NONE, char_byte, addr);
         end else begin
            send_request(OP_CLEAR, char_byte, addr);
         end
      end
   endtask

   // Result side: random back-pressure once a result is waiting
   initial begin : rsp_drain
      int unsigned stall;
      forever begin
         if ($urandom_range(0, 24) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 6);
         if (stall == 0) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
            do @(posedge clock); while (rsp_bus.valid !== 1'b1);
            repeat (stall) @(negedge clock);
            rsp_bus.ready <= 1'b1;
         end
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (rsp_bus.valid && rsp_bus.ready)
         console_model.check_response(rsp_bus.cursor_position, rsp_bus.cell_value);
   end

   // Watchdog: end the run when no transaction moves for too long
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.operation      = OP_PUT;
      req_bus.char_code      = '0;
      req_bus.read_address   = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.text_attribute = '0;
      req_burst              = 1'b0;
      rsp_burst              = 1'b0;
      quiet_cycles           = 0;
      console_model          = new();

      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Blank screen after reset, reads at the grid edges and past it
      send_request(OP_READ, 8'h00, 11'd0);
      send_request(OP_READ, 8'hFF, ADDR_W'(SCREEN_CELLS - 1));
      send_request(OP_READ, 8'h00, ADDR_W'(SCREEN_CELLS));
      send_request(OP_READ, 8'h00, '1);
      // Extreme bytes, backspace down to and at the home position
      send_request(OP_PUT, 8'h00, '0);
      send_request(OP_PUT, 8'hFF, '1);
      send_request(OP_PUT, CHAR_BACKSPACE, '0);
      send_request(OP_PUT, CHAR_BACKSPACE, '0);
      send_request(OP_PUT, CHAR_BACKSPACE, '0);
      send_request(OP_PUT, 8'h41, '0);
      send_request(OP_PUT, CHAR_NEWLINE, '0);
      send_request(OP_NONE, 8'hFF, '1);
      send_request(OP_READ, 8'h00, 11'd0);
      send_request(OP_CLEAR, 8'hFF, '1);
      send_request(OP_READ, 8'h00, 11'd0);

      // Attribute extremes
      write_attribute(8'hFF);
      send_request(OP_PUT, 8'h48, '0);
      send_request(OP_PUT, 8'h7E, '0);
      send_request(OP_READ, 8'h00, 11'd0);
      write_attribute(8'h00);
      send_request(OP_PUT, 8'h5A, '0);
      send_request(OP_READ, 8'h00, 11'd2);
      send_request(OP_PUT, CHAR_NEWLINE, '0);

      // Random traffic under several attributes
      write_attribute(ATTR_W'($urandom_range(1, 254)));
      run_random_phase(PHASE_ITEMS);
      write_attribute(8'hFF);
      run_random_phase(PHASE_ITEMS);
      write_attribute(8'h00);
      run_random_phase(PHASE_ITEMS);
      write_attribute(ATTR_W'($urandom_range(0, 255)));
      run_random_phase(PHASE_ITEMS);

      quiesce();
      if (console_model.mismatches == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
